// File: hw/rtl/sffa_pkg.sv
// Package for the segmented first-fit allocator.
// Holds sizes, block entry type, table command type and result codes; no dependencies.
`timescale 1ns / 1ps
package sffa_pkg;
    localparam int MAX_BLOCKS  = 32;
    localparam int MAX_PIECES  = 6;
    localparam int ADDR_W      = 16;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int PC_W        = $clog2(MAX_PIECES + 1);
    localparam int OWN_W       = 9;

    localparam logic [ADDR_W-1:0] TABLE_WORDS = ADDR_W'(13);
    localparam logic [ADDR_W-1:0] RESET_WORDS = ADDR_W'(4096);
    localparam logic [OWN_W-1:0]  FREE_MARK   = 9'h100;

    localparam logic [1:0] KIND_TABLE = 2'd0;
    localparam logic [1:0] KIND_SEG   = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;
    localparam logic [1:0] KIND_REJ   = 2'd3;

    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_SHORT = 2'd1;
    localparam logic [1:0] CAUSE_MANY  = 2'd2;
    localparam logic [1:0] CAUSE_FULL  = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;

    typedef struct packed {
        logic [OWN_W-1:0]  owner;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] start;
    } t_entry;

    typedef enum logic [2:0] {
        T_NOP   = 3'd0,
        T_WR    = 3'd1,
        T_SPLIT = 3'd2,
        T_SNAP  = 3'd3,
        T_REST  = 3'd4
    } t_top;

    typedef struct packed {
        t_top              op;
        logic [IDX_W-1:0]  idx;
        t_entry            ent;
        logic [ADDR_W-1:0] use_words;
        logic              cnt_we;
        logic [CNT_W-1:0]  cnt;
    } t_tbl_cmd;
endpackage

// File: hw/rtl/sffa_table.sv
// Block table: entry registers, rollback copy and block count.
// Depends on sffa_pkg.
`timescale 1ns / 1ps
module sffa_table import sffa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_init,
    input  logic [ADDR_W-1:0]   i_init_words,
    input  t_tbl_cmd            i_cmd,
    input  logic [IDX_W-1:0]    i_rd_idx,
    output t_entry              o_rd_ent,
    output logic [CNT_W-1:0]    o_count
);
    t_entry           r_ent  [MAX_BLOCKS];
    t_entry           r_keep [MAX_BLOCKS];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_keep_count;
    t_entry           w_base;

    assign o_rd_ent = r_ent[i_rd_idx];
    assign o_count  = r_count;
    assign w_base   = r_ent[i_cmd.idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_ent[0] <= '{owner: FREE_MARK, size: i_rst_n ? i_init_words : RESET_WORDS,
                          start: '0};
            for (int j = 1; j < MAX_BLOCKS; j++) begin
                r_ent[j] <= '{owner: FREE_MARK, size: '0, start: '0};
            end
            r_count <= CNT_W'(1);
            if (!i_rst_n) begin
                r_keep_count <= '0;
            end
        end else begin
            case (i_cmd.op)
                T_WR: begin
                    r_ent[i_cmd.idx] <= i_cmd.ent;
                end
                T_SPLIT: begin
                    for (int j = 1; j < MAX_BLOCKS; j++) begin
                        if (IDX_W'(j) > i_cmd.idx + IDX_W'(1)) begin
                            r_ent[j] <= r_ent[j-1];
                        end
                    end
                    r_ent[i_cmd.idx] <= '{owner: i_cmd.ent.owner, size: i_cmd.use_words,
                                          start: w_base.start};
                    r_ent[i_cmd.idx + IDX_W'(1)] <= '{owner: FREE_MARK,
                        size: w_base.size - i_cmd.use_words,
                        start: w_base.start + i_cmd.use_words};
                    r_count <= r_count + CNT_W'(1);
                end
                T_SNAP: begin
                    r_keep       <= r_ent;
                    r_keep_count <= r_count;
                end
                T_REST: begin
                    r_ent   <= r_keep;
                    r_count <= r_keep_count;
                end
                default: ;
            endcase
            if (i_cmd.cnt_we) begin
                r_count <= i_cmd.cnt;
            end
        end
    end
endmodule

// File: hw/rtl/segmented_first_fit_allocator.sv
// An allocate runs a merge pass, a table snapshot, a table search and a segment pass before its
// first result item is loaded, then loads one result item per cycle while the receiver is ready;
// a free runs one pass over the table before loading its result.
// One request at a time: the next is taken once every result of the last is loaded.
// Reset (synchronous, active low) leaves one free block of 4096 words; a config write, one of i_cfg_data words.
// Depends on sffa_pkg and sffa_table.
`timescale 1ns / 1ps
module segmented_first_fit_allocator import sffa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_req_type,
    input  logic [7:0]        i_owner_id,
    input  logic [15:0]       i_amount,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_result_kind,
    output logic [15:0]       o_base_addr,
    output logic [15:0]       o_length,
    output logic [1:0]        o_reject_cause,
    output logic              o_last
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MERGE = 7'b0000010,
        S_SNAP  = 7'b0000100,
        S_TSCAN = 7'b0001000,
        S_SEG   = 7'b0010000,
        S_FREE  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state            r_state;
    logic [7:0]        r_owner;
    logic [ADDR_W-1:0] r_remain;
    logic [CNT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_wr;
    t_entry            r_acc;
    logic [PC_W-1:0]   r_pieces;
    logic [PC_W-1:0]   r_k;
    logic [ADDR_W-1:0] r_seg_start [MAX_PIECES];
    logic [ADDR_W-1:0] r_seg_len   [MAX_PIECES];
    logic [1:0]        r_kind0;
    logic [ADDR_W-1:0] r_start0;
    logic [ADDR_W-1:0] r_len0;
    logic [1:0]        r_cause0;

    t_tbl_cmd          w_cmd;
    t_entry            w_ent;
    logic [CNT_W-1:0]  w_count;
    logic              w_in_range;
    logic              w_is_free;
    logic [ADDR_W-1:0] w_use;
    logic              w_slot;
    logic              w_reject;
    logic [1:0]        w_cause;

    sffa_table u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (i_cfg_we),
        .i_init_words (i_cfg_data),
        .i_cmd        (w_cmd),
        .i_rd_idx     (r_ptr[IDX_W-1:0]),
        .o_rd_ent     (w_ent),
        .o_count      (w_count)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_range = (r_ptr < w_count);
    assign w_is_free  = (w_ent.owner == FREE_MARK);
    assign w_use      = (w_ent.size < r_remain) ? w_ent.size : r_remain;
    assign w_slot     = !o_valid || i_ready;

    // table command and reject decision
    always_comb begin
        w_cmd    = '{op: T_NOP, idx: r_ptr[IDX_W-1:0], ent: w_ent, use_words: '0,
                     cnt_we: 1'b0, cnt: '0};
        w_reject = 1'b0;
        w_cause  = CAUSE_NONE;
        case (r_state)
            S_MERGE: begin
                if (!w_in_range) begin
                    w_cmd.op     = T_WR;
                    w_cmd.idx    = r_wr[IDX_W-1:0];
                    w_cmd.ent    = r_acc;
                    w_cmd.cnt_we = 1'b1;
                    w_cmd.cnt    = r_wr + CNT_W'(1);
                end else if (r_ptr != '0 && !(r_acc.owner == FREE_MARK && w_is_free &&
                             r_acc.start + r_acc.size == w_ent.start)) begin
                    w_cmd.op  = T_WR;
                    w_cmd.idx = r_wr[IDX_W-1:0];
                    w_cmd.ent = r_acc;
                end
            end
            S_SNAP: begin
                w_cmd.op = T_SNAP;
            end
            S_TSCAN: begin
                if (!w_in_range) begin
                    w_reject = 1'b1;
                    w_cause  = CAUSE_SHORT;
                end else if (w_is_free && w_ent.size >= TABLE_WORDS) begin
                    w_cmd.ent.owner = {1'b0, r_owner};
                    w_cmd.use_words = TABLE_WORDS;
                    if (w_ent.size == TABLE_WORDS) begin
                        w_cmd.op = T_WR;
                    end else if (w_count >= CNT_W'(MAX_BLOCKS)) begin
                        w_reject = 1'b1;
                        w_cause  = CAUSE_FULL;
                    end else begin
                        w_cmd.op = T_SPLIT;
                    end
                end
            end
            S_SEG: begin
                if (!w_in_range || r_remain == '0) begin
                    if (r_remain != '0) begin
                        w_reject = 1'b1;
                        w_cause  = CAUSE_SHORT;
                    end
                end else if (w_is_free && w_ent.size != '0) begin
                    w_cmd.ent.owner = {1'b0, r_owner};
                    w_cmd.use_words = w_use;
                    if (r_pieces >= PC_W'(MAX_PIECES)) begin
                        w_reject = 1'b1;
                        w_cause  = CAUSE_MANY;
                    end else if (w_use == w_ent.size) begin
                        w_cmd.op = T_WR;
                    end else if (w_count >= CNT_W'(MAX_BLOCKS)) begin
                        w_reject = 1'b1;
                        w_cause  = CAUSE_FULL;
                    end else begin
                        w_cmd.op = T_SPLIT;
                    end
                end
            end
            S_FREE: begin
                if (w_in_range && w_ent.owner == {1'b0, r_owner}) begin
                    w_cmd.op        = T_WR;
                    w_cmd.ent.owner = FREE_MARK;
                end
            end
            default: ;
        endcase
        if (w_reject) begin
            w_cmd.op     = T_REST;
            w_cmd.cnt_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && !(r_state == S_EMIT && w_slot)) begin
                o_valid <= 1'b0;
            end
            if (w_reject) begin
                r_kind0  <= KIND_REJ;
                r_start0 <= '0;
                r_len0   <= '0;
                r_cause0 <= w_cause;
                r_pieces <= '0;
                r_k      <= '0;
                r_state  <= S_EMIT;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_valid) begin
                            r_owner  <= i_owner_id;
                            r_remain <= i_amount;
                            r_ptr    <= '0;
                            r_wr     <= '0;
                            r_len0   <= '0;
                            r_state  <= (i_req_type == REQ_ALLOC) ? S_MERGE : S_FREE;
                        end
                    end
                    S_MERGE: begin
                        if (!w_in_range) begin
                            r_state <= S_SNAP;
                        end else begin
                            r_ptr <= r_ptr + CNT_W'(1);
                            if (r_ptr == '0) begin
                                r_acc <= w_ent;
                            end else if (w_cmd.op == T_WR) begin
                                r_acc <= w_ent;
                                r_wr  <= r_wr + CNT_W'(1);
                            end else begin
                                r_acc.size <= r_acc.size + w_ent.size;
                            end
                        end
                    end
                    S_SNAP: begin
                        r_ptr   <= '0;
                        r_state <= S_TSCAN;
                    end
                    S_TSCAN: begin
                        if (w_cmd.op != T_NOP) begin
                            r_kind0  <= KIND_TABLE;
                            r_start0 <= w_ent.start;
                            r_len0   <= TABLE_WORDS;
                            r_cause0 <= CAUSE_NONE;
                            r_pieces <= '0;
                            r_ptr    <= '0;
                            r_state  <= S_SEG;
                        end else begin
                            r_ptr <= r_ptr + CNT_W'(1);
                        end
                    end
                    S_SEG: begin
                        if (!w_in_range || r_remain == '0) begin
                            r_k     <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_ptr <= r_ptr + CNT_W'(1);
                            if (w_cmd.op != T_NOP) begin
                                r_seg_start[r_pieces] <= w_ent.start;
                                r_seg_len[r_pieces]   <= w_use;
                                r_pieces              <= r_pieces + PC_W'(1);
                                r_remain              <= r_remain - w_use;
                            end
                        end
                    end
                    S_FREE: begin
                        if (!w_in_range) begin
                            r_kind0  <= KIND_FREE;
                            r_start0 <= '0;
                            r_cause0 <= CAUSE_NONE;
                            r_pieces <= '0;
                            r_k      <= '0;
                            r_state  <= S_EMIT;
                        end else begin
                            r_ptr <= r_ptr + CNT_W'(1);
                            if (w_cmd.op == T_WR) begin
                                r_len0 <= r_len0 + w_ent.size;
                            end
                        end
                    end
                    S_EMIT: begin
                        if (w_slot) begin
                            o_valid <= 1'b1;
                            o_last  <= (r_k == r_pieces);
                            if (r_k == '0) begin
                                o_result_kind  <= r_kind0;
                                o_base_addr    <= r_start0;
                                o_length       <= r_len0;
                                o_reject_cause <= r_cause0;
                            end else begin
                                o_result_kind  <= KIND_SEG;
                                o_base_addr    <= r_seg_start[r_k - PC_W'(1)];
                                o_length       <= r_seg_len[r_k - PC_W'(1)];
                                o_reject_cause <= CAUSE_NONE;
                            end
                            if (r_k == r_pieces) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_k <= r_k + PC_W'(1);
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

// File: tb/sffa_checker.sv
// Checker for the segmented first-fit allocator: watches both channels and the config port,
// predicts the result items of each request and compares them. Depends on sffa_pkg.
`timescale 1ns / 1ps
module sffa_checker import sffa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_owner_id,
    input  logic [15:0] i_amount,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [1:0]  o_result_kind,
    input  logic [15:0] o_base_addr,
    input  logic [15:0] o_length,
    input  logic [1:0]  o_reject_cause,
    input  logic        o_last,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          rejects_seen
);
    localparam int RESULT_SLOTS = 64;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [1:0]  cause;
        logic        last;
    } t_result;

    t_result           awaited_results[RESULT_SLOTS];
    int                head_ptr;
    int                tail_ptr;
    logic [ADDR_W-1:0] blk_start[MAX_BLOCKS];
    logic [ADDR_W-1:0] blk_size[MAX_BLOCKS];
    logic [OWN_W-1:0]  blk_owner[MAX_BLOCKS];
    int                blk_count;
    logic [ADDR_W-1:0] saved_start[MAX_BLOCKS];
    logic [ADDR_W-1:0] saved_size[MAX_BLOCKS];
    logic [OWN_W-1:0]  saved_owner[MAX_BLOCKS];
    int                saved_count;

    function automatic void add_result(t_result r);
        awaited_results[tail_ptr % RESULT_SLOTS] = r;
        tail_ptr++;
    endfunction

    function automatic void clear_table(logic [15:0] words);
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            blk_start[k] = '0;
            blk_size[k]  = '0;
            blk_owner[k] = FREE_MARK;
        end
        blk_size[0] = words;
        blk_count   = 1;
    endfunction

    function automatic void coalesce();
        int i;
        i = 0;
        while (i + 1 < blk_count) begin
            if (blk_owner[i] == FREE_MARK && blk_owner[i+1] == FREE_MARK &&
                    ADDR_W'(blk_start[i] + blk_size[i]) == blk_start[i+1]) begin
                blk_size[i] = blk_size[i] + blk_size[i+1];
                for (int j = i + 1; j + 1 < blk_count; j++) begin
                    blk_start[j] = blk_start[j+1];
                    blk_size[j]  = blk_size[j+1];
                    blk_owner[j] = blk_owner[j+1];
                end
                blk_count--;
                blk_owner[blk_count] = FREE_MARK;
                blk_size[blk_count]  = '0;
                blk_start[blk_count] = '0;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic bit claim(int i, logic [ADDR_W-1:0] words, logic [OWN_W-1:0] own);
        if (words == blk_size[i]) begin
            blk_owner[i] = own;
            return 1'b1;
        end
        if (blk_count >= MAX_BLOCKS) return 1'b0;
        for (int j = blk_count; j > i; j--) begin
            blk_start[j] = blk_start[j-1];
            blk_size[j]  = blk_size[j-1];
            blk_owner[j] = blk_owner[j-1];
        end
        blk_count++;
        blk_size[i]    = words;
        blk_owner[i]   = own;
        blk_start[i+1] = blk_start[i+1] + words;
        blk_size[i+1]  = blk_size[i+1] - words;
        return 1'b1;
    endfunction

    function automatic void roll_back(logic [1:0] cause);
        blk_start = saved_start;
        blk_size  = saved_size;
        blk_owner = saved_owner;
        blk_count = saved_count;
        add_result('{KIND_REJ, 16'd0, 16'd0, cause, 1'b1});
    endfunction

    function automatic void predict_alloc(logic [7:0] owner, logic [15:0] amount);
        logic [ADDR_W-1:0] seg_at[MAX_PIECES];
        logic [ADDR_W-1:0] seg_len[MAX_PIECES];
        logic [ADDR_W-1:0] table_at;
        logic [ADDR_W-1:0] words;
        logic [OWN_W-1:0]  own;
        int                pieces;
        int                remaining;
        int                i;
        bit                found;
        own       = {1'b0, owner};
        pieces    = 0;
        remaining = amount;
        found     = 1'b0;
        table_at  = '0;
        coalesce();
        saved_start = blk_start;
        saved_size  = blk_size;
        saved_owner = blk_owner;
        saved_count = blk_count;
        for (i = 0; i < blk_count; i++) begin
            if (blk_owner[i] == FREE_MARK && blk_size[i] >= TABLE_WORDS) begin
                table_at = blk_start[i];
                if (!claim(i, TABLE_WORDS, own)) begin
                    roll_back(CAUSE_FULL);
                    return;
                end
                found = 1'b1;
                break;
            end
        end
        if (!found) begin
            roll_back(CAUSE_SHORT);
            return;
        end
        for (i = 0; i < blk_count && remaining > 0; i++) begin
            if (blk_owner[i] != FREE_MARK || blk_size[i] == 0) continue;
            if (pieces >= MAX_PIECES) begin
                roll_back(CAUSE_MANY);
                return;
            end
            words = (blk_size[i] < remaining) ? blk_size[i] : ADDR_W'(remaining);
            seg_at[pieces]  = blk_start[i];
            seg_len[pieces] = words;
            pieces++;
            remaining -= words;
            if (!claim(i, words, own)) begin
                roll_back(CAUSE_FULL);
                return;
            end
        end
        if (remaining > 0) begin
            roll_back(CAUSE_SHORT);
            return;
        end
        add_result('{KIND_TABLE, table_at, TABLE_WORDS, CAUSE_NONE, pieces == 0});
        for (i = 0; i < pieces; i++)
            add_result('{KIND_SEG, seg_at[i], seg_len[i], CAUSE_NONE, i + 1 == pieces});
    endfunction

    function automatic void predict_release(logic [7:0] owner);
        logic [15:0] total;
        total = '0;
        for (int i = 0; i < blk_count; i++) begin
            if (blk_owner[i] == {1'b0, owner}) begin
                blk_owner[i] = FREE_MARK;
                total = total + blk_size[i];
            end
        end
        add_result('{KIND_FREE, 16'd0, total, CAUSE_NONE, 1'b1});
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    initial begin
        fail_count      = 0;
        pending         = 0;
        results_checked = 0;
        rejects_seen    = 0;
        head_ptr        = 0;
        tail_ptr        = 0;
        clear_table(RESET_WORDS);
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            clear_table(RESET_WORDS);
            head_ptr = 0;
            tail_ptr = 0;
        end else begin
            if (i_cfg_we) clear_table(i_cfg_data);
            if (i_valid && o_ready) begin
                if (i_req_type == REQ_ALLOC) predict_alloc(i_owner_id, i_amount);
                else predict_release(i_owner_id);
            end
            if (o_valid && i_ready) begin
                results_checked++;
                if (o_result_kind == KIND_REJ) rejects_seen++;
                if (tail_ptr == head_ptr) begin
                    $error("result item with none expected: kind %0d", o_result_kind);
                    fail_count++;
                end else begin
                    exp_r = awaited_results[head_ptr % RESULT_SLOTS];
                    head_ptr++;
                    check_field("result_kind", exp_r.kind, o_result_kind);
                    check_field("base_addr", exp_r.start, o_base_addr);
                    check_field("length", exp_r.len, o_length);
                    check_field("reject_cause", exp_r.cause, o_reject_cause);
                    check_field("last", exp_r.last, o_last);
                end
            end
        end
        pending = tail_ptr - head_ptr;
    end
endmodule

// File: tb/segmented_first_fit_allocator_test.sv
// Top of the allocator testbench: clock, reset, request stimulus, config writes and verdict.
// Depends on sffa_pkg, segmented_first_fit_allocator and sffa_checker.
`timescale 1ns / 1ps
module segmented_first_fit_allocator_test import sffa_pkg::*;;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 150;

    logic        i_clk, i_rst_n, i_cfg_we, i_valid, o_ready, i_req_type, o_valid, i_ready;
    logic [15:0] i_cfg_data, i_amount, o_base_addr, o_length;
    logic [7:0]  i_owner_id;
    logic [1:0]  o_result_kind, o_reject_cause;
    logic        o_last;
    int          fail_count, pending, results_checked, rejects_seen;
    int          cycle_count, requests_sent, send_idle_pct, recv_idle_pct;

    segmented_first_fit_allocator DUT (.*);

    sffa_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_request(logic req, logic [7:0] owner, logic [15:0] amount);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_req_type = req;
        i_owner_id = owner;
        i_amount   = amount;
        do @(posedge i_clk); while (!o_ready);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_words(logic [15:0] words);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = words;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic random_requests(int n);
        logic [15:0] amount;
        logic [7:0]  owner;
        for (int k = 0; k < n; k++) begin
            owner = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
            case ($urandom_range(0, 9))
                0:       amount = 16'($urandom);
                1, 2:    amount = 16'($urandom_range(0, 600));
                default: amount = 16'($urandom_range(0, 40));
            endcase
            send_request(($urandom_range(0, 9) < 3) ? ~REQ_ALLOC : REQ_ALLOC, owner, amount);
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0; i_valid = 1'b0;
        i_req_type = REQ_ALLOC; i_owner_id = '0; i_amount = '0; i_ready = 1'b0;
        requests_sent = 0;
        send_idle_pct = 37;
        recv_idle_pct = 74;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(REQ_ALLOC, 8'd0, 16'd0);
        send_request(REQ_ALLOC, 8'd255, 16'hFFFF);
        send_request(REQ_ALLOC, 8'd1, 16'd100);
        send_request(~REQ_ALLOC, 8'd1, 16'hFFFF);
        send_request(~REQ_ALLOC, 8'd77, 16'd0);
        drain();
        for (int k = 0; k < 12; k++) send_request(REQ_ALLOC, 8'(10 + k), 16'd5);
        for (int k = 0; k < 12; k += 2) send_request(~REQ_ALLOC, 8'(10 + k), 16'd0);
        send_request(REQ_ALLOC, 8'd40, 16'd4000);
        send_request(REQ_ALLOC, 8'd41, 16'd3000);
        random_requests(63);

        send_idle_pct = 74;
        recv_idle_pct = 37;
        write_words(16'hFFFF);
        send_request(REQ_ALLOC, 8'd3, 16'hFFF0);
        random_requests(63);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_words(16'd13);
        send_request(REQ_ALLOC, 8'd5, 16'd0);
        send_request(REQ_ALLOC, 8'd6, 16'd0);
        write_words(16'd12);
        send_request(REQ_ALLOC, 8'd5, 16'd1);
        write_words(16'd0);
        send_request(REQ_ALLOC, 8'd5, 16'd0);
        write_words(16'd300);
        random_requests(63);

        drain();
        $display("Sent %0d requests over config settings 4096, 65535, 13, 12, 0 and 300;",
                 requests_sent);
        $display("checked %0d result items, %0d of them rejections.",
                 results_checked, rejects_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
hw/rtl/sffa_pkg.sv
hw/rtl/sffa_table.sv
hw/rtl/segmented_first_fit_allocator.sv
tb/sffa_checker.sv
tb/segmented_first_fit_allocator_test.sv
